// File: rtl/tdf_pkg.sv
// Shared types, constants and state codes of the trial division factorizer.
package tdf_pkg;

  // Width of the value being factored and of the divider
  localparam int VALUE_WIDTH = 32;
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);

  // Field widths on the ports
  localparam int NUMBER_W = 32;
  localparam int PRIME_W  = 32;
  localparam int EXPO_W   = 6;
  localparam int OUT_DATA_W = 40;

  localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT_NONE,
    S_DIV,
    S_DIV_WAIT,
    S_DECIDE,
    S_FLUSH,
    S_FINISH
  } tdf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // take a new number, divisor back to two
    logic div_start;   // start a division remainder / divisor
    logic take;        // divisor divides again: keep quotient, count up
    logic start_run;   // new prime found: hold it with count one
    logic end_run;     // run of the held prime ends, advance divisor
    logic next_d;      // advance divisor
    logic out_none;    // emit the no-factor result
    logic out_held;    // emit the held prime
    logic out_rem;     // emit the leftover remainder as a prime
    logic out_last;    // last flag for out_held
    logic clear_held;  // held prime has been emitted
  } tdf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_small;   // number on the input is below two
    logic div_done;   // division finished this cycle
    logic r_zero;     // division left no remainder
    logic d_gt_q;     // divisor exceeds quotient: divisor squared > remainder
    logic in_run;     // divisor equals the held prime
    logic held_v;     // a found prime waits to be emitted
    logic rem_gt1;    // remainder above one
    logic slot_free;  // output register can take a result
  } tdf_status_t;

endpackage

// File: rtl/tdf_divider.sv
// Restoring divider, one quotient bit per cycle.
module tdf_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tdf_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [tdf_pkg::VALUE_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [tdf_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [tdf_pkg::VALUE_WIDTH-1:0] remainder
);
  import tdf_pkg::*;

  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  // Shift in the next dividend bit and try to subtract
  assign shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  // Step the division
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(VALUE_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/tdf_datapath.sv
// Datapath: remainder, trial divisor, held prime, divider and output register.
module tdf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tdf_pkg::NUMBER_W-1:0]   number,
  input  tdf_pkg::tdf_cmd_t              cmd,
  output tdf_pkg::tdf_status_t           st,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [tdf_pkg::PRIME_W-1:0]    out_prime,
  output logic [tdf_pkg::EXPO_W-1:0]     out_expo,
  output logic                           out_last,
  output logic                           out_none
);
  import tdf_pkg::*;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH-1:0] held_p_r, held_p_nxt;
  logic [EXPO_W-1:0]      held_c_r, held_c_nxt;
  logic                   held_v_r, held_v_nxt;
  logic                   in_run_r, in_run_nxt;
  logic                   ov_r, ov_nxt;
  logic [PRIME_W-1:0]     op_r, op_nxt;
  logic [EXPO_W-1:0]      oe_r, oe_nxt;
  logic                   ol_r, ol_nxt;
  logic                   on_r, on_nxt;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rmd;

  // Keep the low bits of the input number
  assign value = VALUE_WIDTH'(number);

  tdf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rem_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rmd)
  );

  // Update the factoring state
  always_comb begin
    rem_nxt    = rem_r;
    d_nxt      = d_r;
    held_p_nxt = held_p_r;
    held_c_nxt = held_c_r;
    held_v_nxt = held_v_r;
    in_run_nxt = in_run_r;
    if (cmd.load) begin
      rem_nxt    = value;
      d_nxt      = FIRST_DIVISOR;
      held_v_nxt = 1'b0;
      in_run_nxt = 1'b0;
    end
    if (cmd.take) begin
      rem_nxt    = quo;
      held_c_nxt = held_c_r + 1'b1;
    end
    if (cmd.start_run) begin
      rem_nxt    = quo;
      held_p_nxt = d_r;
      held_c_nxt = EXPO_W'(1);
      held_v_nxt = 1'b1;
      in_run_nxt = 1'b1;
    end
    if (cmd.end_run) begin
      in_run_nxt = 1'b0;
      d_nxt      = d_r + 1'b1;
    end
    if (cmd.next_d) begin
      d_nxt = d_r + 1'b1;
    end
    if (cmd.clear_held) begin
      held_v_nxt = 1'b0;
    end
  end

  // Load the output register; drop a result once it is taken
  always_comb begin
    ov_nxt = ov_r & ~out_ready;
    op_nxt = op_r;
    oe_nxt = oe_r;
    ol_nxt = ol_r;
    on_nxt = on_r;
    if (cmd.out_none) begin
      ov_nxt = 1'b1;
      op_nxt = '0;
      oe_nxt = '0;
      ol_nxt = 1'b1;
      on_nxt = 1'b1;
    end else if (cmd.out_held) begin
      ov_nxt = 1'b1;
      op_nxt = PRIME_W'(held_p_r);
      oe_nxt = held_c_r;
      ol_nxt = cmd.out_last;
      on_nxt = 1'b0;
    end else if (cmd.out_rem) begin
      ov_nxt = 1'b1;
      op_nxt = PRIME_W'(rem_r);
      oe_nxt = EXPO_W'(1);
      ol_nxt = 1'b1;
      on_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      d_r      <= FIRST_DIVISOR;
      held_v_r <= 1'b0;
      in_run_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      d_r      <= d_nxt;
      held_v_r <= held_v_nxt;
      in_run_r <= in_run_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_p_r <= held_p_nxt;
    held_c_r <= held_c_nxt;
    op_r     <= op_nxt;
    oe_r     <= oe_nxt;
    ol_r     <= ol_nxt;
    on_r     <= on_nxt;
  end

  // Status toward the controller
  always_comb begin
    st.in_small  = (value < VALUE_WIDTH'(2));
    st.div_done  = div_done;
    st.r_zero    = (rmd == '0);
    st.d_gt_q    = (d_r > quo);
    st.in_run    = in_run_r;
    st.held_v    = held_v_r;
    st.rem_gt1   = (rem_r > VALUE_WIDTH'(1));
    st.slot_free = ~ov_r | out_ready;
  end

  assign out_valid = ov_r;
  assign out_prime = op_r;
  assign out_expo  = oe_r;
  assign out_last  = ol_r;
  assign out_none  = on_r;

endmodule

// File: rtl/tdf_ctrl.sv
// Controller: sequences divisions and result emission for one number.
module tdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tdf_pkg::tdf_status_t st,
  output tdf_pkg::tdf_cmd_t    cmd
);
  import tdf_pkg::*;

  tdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = st.in_small ? S_EMIT_NONE : S_DIV;
        end
      end
      S_EMIT_NONE: begin
        if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.in_run) begin
          state_nxt = S_DIV;
        end else if (st.d_gt_q) begin
          state_nxt = S_FINISH;
        end else if (st.r_zero && st.held_v) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_FLUSH: begin
        if (st.slot_free) begin
          state_nxt = S_DIV;
        end
      end
      S_FINISH: begin
        if (st.slot_free && !(st.rem_gt1 && st.held_v)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EMIT_NONE: begin
        cmd.out_none = st.slot_free;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
      end
      S_DECIDE: begin
        if (st.in_run) begin
          cmd.take    = st.r_zero;
          cmd.end_run = ~st.r_zero;
        end else if (!st.d_gt_q) begin
          if (!st.r_zero) begin
            cmd.next_d = 1'b1;
          end else if (!st.held_v) begin
            cmd.start_run = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        // Emit the previous prime and hold the new one in the same cycle
        if (st.slot_free) begin
          cmd.out_held  = 1'b1;
          cmd.start_run = 1'b1;
        end
      end
      S_FINISH: begin
        if (st.slot_free) begin
          if (st.held_v) begin
            cmd.out_held   = 1'b1;
            cmd.out_last   = ~st.rem_gt1;
            cmd.clear_held = 1'b1;
          end else begin
            cmd.out_rem = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/trial_division_factorizer_top.sv
// Top level of the trial division factorizer.
//
// The input channel takes one unsigned 32-bit number per transaction. For
// each number the block emits a run of (prime, exponent) results in
// increasing prime order on the output channel; tlast marks the final
// result of the run. A number below two gives a single result with prime 0,
// exponent 0, tlast set and the none flag (out_tuser) set.
// Divisors are tried upward from two until the divisor squared exceeds the
// remainder; a leftover above one is emitted as a prime with exponent one.
// Each trial costs one pass of the bit-serial divider (start, 32 divider
// steps, done and decision). The cost of a number grows with the number
// of trial divisors and found multiplicities, and is largest for a 32-bit
// prime near the top of the range.
// One number is factored at a time; in_tready is high only while idle.
// A result sits in an output register; while the receiver stalls, the
// factoring stops at the next result until that register is taken, and
// the next number is accepted as soon as the last result is loaded.
// Synchronous active-low reset returns the block to idle with no result
// pending.
module trial_division_factorizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] prime, [37:32] exponent, [39:38] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] none_found
);
  import tdf_pkg::*;

  tdf_cmd_t           cmd;
  tdf_status_t        st;
  logic [PRIME_W-1:0] prime;
  logic [EXPO_W-1:0]  expo;

  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tdf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .number    (in_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_prime (prime),
    .out_expo  (expo),
    .out_last  (out_tlast),
    .out_none  (out_tuser)
  );

  // Pack the result fields
  assign out_tdata = {2'b00, expo, prime};

  // A result is loaded only when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_none || cmd.out_held || cmd.out_rem) |-> st.slot_free)
    else $error("result loaded into an occupied output register");

  // At most one result source per cycle
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_none, cmd.out_held, cmd.out_rem}))
    else $error("two result sources in one cycle");

  // A no-factor result is always the end of its run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("no-factor result without tlast");

  // A new prime is held only after the previous run has ended
  a_new_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_run |-> !st.in_run)
    else $error("new prime started during a run");

endmodule
